[hw/rtl/brsm_pkg.sv]
// Shared types and constants for the block range segment mapper.
`timescale 1ns / 1ps
`default_nettype none
package brsm_pkg;

    localparam int MAX_BLOCKS      = 64;
    localparam int MAX_BLOCK_BYTES = 1048576;
    localparam int IDX_W           = $clog2(MAX_BLOCKS);
    localparam int CNT_W           = IDX_W + 1;
    localparam int BLK_W           = 21;
    localparam int FLEN_W          = 27;
    localparam int POS_W           = 32;

    // request kinds
    localparam logic REQ_APPEND = 1'b0;
    localparam logic REQ_MAP    = 1'b1;

    // result status codes
    localparam logic [1:0] ST_SEGMENT     = 2'd0;
    localparam logic [1:0] ST_APPEND_OK   = 2'd1;
    localparam logic [1:0] ST_APPEND_FULL = 2'd2;

    typedef struct packed {
        logic             req_type;
        logic [BLK_W-1:0] block_length;
        logic [POS_W-1:0] range_offset;
        logic [POS_W-1:0] range_length;
    } cmd_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [5:0]        block_index;
        logic [BLK_W-1:0]  begin_pos;
        logic [BLK_W-1:0]  read_length;
        logic [FLEN_W-1:0] file_length;
        logic              is_last;
    } res_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [BLK_W-1:0] data;
    } tbl_wr_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } tbl_rd_t;

endpackage
`default_nettype wire

[hw/rtl/brsm_table.sv]
// Block length table: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module brsm_table (
    input  wire logic                    clk,
    input  wire brsm_pkg::tbl_wr_t       wr,
    input  wire brsm_pkg::tbl_rd_t       rd,
    output logic [brsm_pkg::BLK_W-1:0]   rd_data
);
    import brsm_pkg::*;

    logic [BLK_W-1:0] mem [MAX_BLOCKS];
    logic [BLK_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

[hw/rtl/brsm_seq.sv]
// Sequencer: appends block lengths, walks the table for map requests.
`timescale 1ns / 1ps
`default_nettype none
module brsm_seq (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cmd_valid,
    output logic                        cmd_stall,
    input  wire brsm_pkg::cmd_t         cmd,
    output logic                        seg_valid,
    input  wire logic                   seg_stall,
    output brsm_pkg::res_t              seg,
    output brsm_pkg::tbl_wr_t           wr,
    output brsm_pkg::tbl_rd_t           rd,
    input  wire logic [brsm_pkg::BLK_W-1:0] rd_data
);
    import brsm_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_EMIT
    } state_t;

    state_t              state_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [FLEN_W-1:0]   total_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [POS_W-1:0]    off_reg;
    logic [POS_W:0]      end_reg;
    logic [FLEN_W-1:0]   bbeg_reg;
    res_t                pend_reg;
    logic                pend_v_reg;

    logic                accept;
    logic                full;
    logic [BLK_W-1:0]    clamp_len;
    logic [FLEN_W-1:0]   total_sum;
    logic [POS_W:0]      bbeg_w;
    logic [POS_W:0]      bend_w;
    logic [POS_W:0]      off_w;
    logic [POS_W:0]      lo_w;
    logic [POS_W:0]      hi_w;
    logic                past_end;
    logic                hit;
    logic                last_entry;
    logic                emit_wait;
    res_t                new_seg;

    assign cmd_stall = (state_reg != S_IDLE);
    assign accept    = cmd_valid && !cmd_stall;
    assign full      = (count_reg == CNT_W'(MAX_BLOCKS));

    assign clamp_len = (32'(cmd.block_length) > 32'(MAX_BLOCK_BYTES))
                     ? BLK_W'(MAX_BLOCK_BYTES) : cmd.block_length;
    assign total_sum = total_reg + FLEN_W'(clamp_len);

    // current block span [bbeg, bend) against range [off, end)
    assign bbeg_w     = (POS_W+1)'(bbeg_reg);
    assign bend_w     = bbeg_w + (POS_W+1)'(rd_data);
    assign off_w      = {1'b0, off_reg};
    assign past_end   = (bbeg_w >= end_reg);
    assign hit        = !past_end && (bend_w > off_w);
    assign lo_w       = (off_w > bbeg_w) ? off_w : bbeg_w;
    assign hi_w       = (end_reg < bend_w) ? end_reg : bend_w;
    assign last_entry = (({1'b0, idx_reg} + CNT_W'(1)) == count_reg);
    // a new hit must first push out the held segment
    assign emit_wait  = hit && pend_v_reg && seg_stall;

    always_comb
    begin
        new_seg             = '0;
        new_seg.status      = ST_SEGMENT;
        new_seg.block_index = 6'(idx_reg);
        new_seg.begin_pos   = BLK_W'(lo_w - bbeg_w);
        new_seg.read_length = BLK_W'(hi_w - lo_w);
        new_seg.file_length = total_reg;
    end

    always_comb
    begin
        seg         = pend_reg;
        seg.is_last = (state_reg == S_EMIT);
    end
    assign seg_valid = (state_reg == S_EMIT) || (state_reg == S_WALK && hit && pend_v_reg);

    assign wr.en   = accept && (cmd.req_type == REQ_APPEND) && !full;
    assign wr.addr = IDX_W'(count_reg);
    assign wr.data = clamp_len;

    assign rd.en   = (accept && (cmd.req_type == REQ_MAP) && (count_reg != '0))
                   || (state_reg == S_WALK && !emit_wait && !past_end && !last_entry);
    assign rd.addr = (state_reg == S_IDLE) ? '0 : idx_reg + IDX_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            total_reg  <= '0;
            pend_v_reg <= 1'b0;
            idx_reg    <= '0;
            off_reg    <= '0;
            end_reg    <= '0;
            bbeg_reg   <= '0;
            pend_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (cmd.req_type == REQ_APPEND)
                        begin
                            pend_reg <= '0;
                            if (full)
                            begin
                                pend_reg.status      <= ST_APPEND_FULL;
                                pend_reg.file_length <= total_reg;
                            end
                            else
                            begin
                                pend_reg.status      <= ST_APPEND_OK;
                                pend_reg.block_index <= 6'(count_reg);
                                pend_reg.file_length <= total_sum;
                                total_reg            <= total_sum;
                                count_reg            <= count_reg + CNT_W'(1);
                            end
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            off_reg    <= cmd.range_offset;
                            end_reg    <= {1'b0, cmd.range_offset} + {1'b0, cmd.range_length};
                            bbeg_reg   <= '0;
                            idx_reg    <= '0;
                            pend_v_reg <= 1'b0;
                            state_reg  <= (count_reg != '0) ? S_WALK : S_IDLE;
                        end
                    end
                end
                S_WALK:
                begin
                    if (!emit_wait)
                    begin
                        bbeg_reg <= FLEN_W'(bend_w);
                        if (hit)
                        begin
                            pend_reg   <= new_seg;
                            pend_v_reg <= 1'b1;
                        end
                        if (past_end)
                        begin
                            state_reg <= pend_v_reg ? S_EMIT : S_IDLE;
                        end
                        else if (last_entry)
                        begin
                            state_reg <= (hit || pend_v_reg) ? S_EMIT : S_IDLE;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + IDX_W'(1);
                        end
                    end
                end
                S_EMIT:
                begin
                    if (!seg_stall)
                    begin
                        state_reg  <= S_IDLE;
                        pend_v_reg <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_BLOCKS))
        else $error("block count beyond table depth");

    a_walk_index: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WALK |-> ({1'b0, idx_reg} < count_reg))
        else $error("walk index beyond stored blocks");

    a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && seg_stall) |=> (state_reg == S_EMIT && $stable(pend_reg)))
        else $error("final item lost while stalled");

    a_total_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !wr.en |=> $stable(total_reg) && $stable(count_reg))
        else $error("table totals changed without an append");
`endif

endmodule
`default_nettype wire

[hw/rtl/block_range_segment_mapper.sv]
// Block range segment mapper: top level with output register.
// Usage:
//   Command channel cmd_valid / cmd_stall / cmd carries one request item.
//   An append stores a block length (clamped to the maximum block size)
//   and answers with one item: status append accepted with the block index
//   and new file length, or append rejected when the table is full.
//   A map walks the stored blocks in order, one table entry per cycle unless
//   a stalled receiver holds it up, and answers with one segment item per
//   overlapping block; is_last marks the final one. A map overlapping no block answers nothing.
//   Result channel res_valid / res_stall / res is driven from a register.
//   Commands are taken one at a time: cmd_stall holds while an append or
//   a map is in progress, and the walk is paced by the single read port of the
//   block length table. The result register lets a new command enter while
//   the last result of the previous one still waits.
//   A stalled receiver holds the result register; the walk then pauses
//   until the held segment is taken.
//   Reset clears the block count, total length and all valid flags; the
//   table contents are not cleared and are only read below the count.
`timescale 1ns / 1ps
`default_nettype none
module block_range_segment_mapper (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cmd_valid,
    output logic                 cmd_stall,
    input  wire brsm_pkg::cmd_t  cmd,
    output logic                 res_valid,
    input  wire logic            res_stall,
    output brsm_pkg::res_t       res
);
    import brsm_pkg::*;

    tbl_wr_t           wr;
    tbl_rd_t           rd;
    logic [BLK_W-1:0]  rd_data;
    logic              seg_valid;
    logic              seg_stall;
    res_t              seg;
    logic              res_valid_reg;
    res_t              res_reg;

    brsm_table u_table (
        .clk     (clk),
        .wr      (wr),
        .rd      (rd),
        .rd_data (rd_data)
    );

    brsm_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .seg_valid (seg_valid),
        .seg_stall (seg_stall),
        .seg       (seg),
        .wr        (wr),
        .rd        (rd),
        .rd_data   (rd_data)
    );

    assign seg_stall = res_valid_reg && res_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else if (seg_valid && !seg_stall)
        begin
            res_valid_reg <= 1'b1;
            res_reg       <= seg;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule
`default_nettype wire
